[rtl/core/rne_pkg.sv]
`default_nettype none

package rne_pkg;

  localparam int unsigned ValueW  = 12;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned NumDig  = 4;
  localparam int unsigned BcdW    = DigitW * NumDig;
  localparam int unsigned CountW  = 4;
  localparam int unsigned SymW    = 8;
  localparam int unsigned PlaceW  = 2;
  localparam int unsigned PosW    = 2;

  localparam logic [ValueW-1:0] MaxValid = ValueW'(3999);

  localparam logic [SymW-1:0] SymNone = 8'h00;
  localparam logic [SymW-1:0] SymI    = 8'h49;
  localparam logic [SymW-1:0] SymV    = 8'h56;
  localparam logic [SymW-1:0] SymX    = 8'h58;
  localparam logic [SymW-1:0] SymL    = 8'h4C;
  localparam logic [SymW-1:0] SymC    = 8'h43;
  localparam logic [SymW-1:0] SymD    = 8'h44;
  localparam logic [SymW-1:0] SymM    = 8'h4D;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } state_e;

  // index of the final character that a decimal digit writes
  function automatic logic [PosW-1:0] last_pos(input logic [DigitW-1:0] d);
    logic [PosW-1:0] r;
    case (d)
      4'd1, 4'd5:               r = 2'd0;
      4'd2, 4'd4, 4'd6, 4'd9:   r = 2'd1;
      4'd3, 4'd7:               r = 2'd2;
      4'd8:                     r = 2'd3;
      default:                  r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [SymW-1:0] unit_sym(input logic [PlaceW-1:0] p);
    logic [SymW-1:0] r;
    case (p)
      2'd0:    r = SymI;
      2'd1:    r = SymX;
      2'd2:    r = SymC;
      default: r = SymM;
    endcase
    return r;
  endfunction

  function automatic logic [SymW-1:0] five_sym(input logic [PlaceW-1:0] p);
    logic [SymW-1:0] r;
    case (p)
      2'd0:    r = SymV;
      2'd1:    r = SymL;
      2'd2:    r = SymD;
      default: r = SymNone;
    endcase
    return r;
  endfunction

  function automatic logic [SymW-1:0] ten_sym(input logic [PlaceW-1:0] p);
    logic [SymW-1:0] r;
    case (p)
      2'd0:    r = SymX;
      2'd1:    r = SymC;
      2'd2:    r = SymM;
      default: r = SymNone;
    endcase
    return r;
  endfunction

  // character at position k of digit d in decimal place p
  function automatic logic [SymW-1:0] digit_sym(input logic [DigitW-1:0] d,
                                                input logic [PlaceW-1:0] p,
                                                input logic [PosW-1:0]   k);
    logic [SymW-1:0] r;
    if (d == 4'd9) begin
      r = (k == 2'd0) ? unit_sym(p) : ten_sym(p);
    end else if (d == 4'd4) begin
      r = (k == 2'd0) ? unit_sym(p) : five_sym(p);
    end else if (d >= 4'd5) begin
      r = (k == 2'd0) ? five_sym(p) : unit_sym(p);
    end else begin
      r = unit_sym(p);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/roman_numeral_encoder_core.sv]
`default_nettype none

// Roman numeral encoder. An item is taken when start is high and busy is low;
// values 1 to 3999 come out as ASCII characters, most significant first, on
// valid_o, with last_o on the final one. Characters come one per cycle, with a
// gap for each zero digit skipped ahead of a nonzero one. Zero gives no
// result. Values above 3999 give one result, in the cycle after acceptance,
// with error_o set and symbol 0, and the block stays ready. For a valid value,
// busy stays high through bit-serial binary to BCD conversion (one value bit
// per cycle through the BCD shift register), then while the characters are
// emitted and zero digits skipped. Results are shown for one cycle only; the
// receiver cannot stall them.
module roman_numeral_encoder_core
  import rne_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   valid_o,
  output logic [SymW-1:0]        symbol_o,
  output logic                   last_o,
  output logic                   error_o
);

  state_e              state_q, state_d;
  logic [ValueW-1:0]   bin_q, bin_d;
  logic [BcdW-1:0]     bcd_q, bcd_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [PlaceW-1:0]   place_q, place_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic                valid_q, valid_d;
  logic [SymW-1:0]     sym_q, sym_d;
  logic                last_q, last_d;
  logic                err_q, err_d;

  logic [BcdW-1:0]     bcd_adj;
  logic [DigitW-1:0]   cur_dig;
  logic                low_zero;
  logic                dig_end;

  // add-3 correction on each bcd digit before the shift
  always_comb begin
    for (int i = 0; i < NumDig; i++) begin
      if (bcd_q[i*DigitW +: DigitW] >= 4'd5) begin
        bcd_adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW] + 4'd3;
      end else begin
        bcd_adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW];
      end
    end
  end

  assign cur_dig  = bcd_q[BcdW-1 -: DigitW];
  assign low_zero = (bcd_q[BcdW-DigitW-1:0] == '0);
  assign dig_end  = (pos_q == last_pos(cur_dig));

  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    place_d = place_q;
    pos_d   = pos_q;
    valid_d = 1'b0;
    sym_d   = sym_q;
    last_d  = last_q;
    err_d   = err_q;
    case (state_q)
      StIdle: begin
        if (start) begin
          if (value_i > MaxValid) begin
            valid_d = 1'b1;
            sym_d   = SymNone;
            last_d  = 1'b1;
            err_d   = 1'b1;
          end else if (value_i != '0) begin
            bin_d   = value_i;
            bcd_d   = '0;
            cnt_d   = '0;
            state_d = StConv;
          end
        end
      end
      StConv: begin
        bcd_d = {bcd_adj[BcdW-2:0], bin_q[ValueW-1]};
        bin_d = {bin_q[ValueW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CountW'(ValueW - 1)) begin
          place_d = PlaceW'(NumDig - 1);
          pos_d   = '0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (cur_dig == '0) begin
          // a zero digit writes nothing
          bcd_d   = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
          place_d = place_q - 1'b1;
        end else begin
          valid_d = 1'b1;
          sym_d   = digit_sym(cur_dig, place_q, pos_q);
          last_d  = dig_end && low_zero;
          err_d   = 1'b0;
          if (dig_end) begin
            bcd_d   = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
            place_d = place_q - 1'b1;
            pos_d   = '0;
            if (low_zero) begin
              state_d = StIdle;
            end
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    bcd_q   <= bcd_d;
    cnt_q   <= cnt_d;
    place_q <= place_d;
    pos_q   <= pos_d;
    sym_q   <= sym_d;
    last_q  <= last_d;
    err_q   <= err_d;
  end

  assign busy     = (state_q != StIdle);
  assign valid_o  = valid_q;
  assign symbol_o = sym_q;
  assign last_o   = last_q;
  assign error_o  = err_q;

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && error_o |-> last_o && (symbol_o == SymNone))
    else $error("error item not a single zero symbol");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (bcd_q != '0))
    else $error("emitting with no digits left");

  a_conv_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StConv) |-> !valid_o)
    else $error("result during conversion");

  a_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !error_o |-> (symbol_o != SymNone))
    else $error("empty character emitted");

endmodule

`default_nettype wire

[dv/roman_numeral_encoder_core_tb.sv]
`timescale 1ns / 1ps

module roman_numeral_encoder_core_tb
  import rne_pkg::*;
();

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last;
    logic            error;
  } roman_char_t;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start   = 1'b0;
  logic [ValueW-1:0] value_i = '0;
  logic              busy;
  logic              valid_o;
  logic [SymW-1:0]   symbol_o;
  logic              last_o;
  logic              error_o;

  roman_char_t pending_chars[$];
  int unsigned mismatch_count = 0;
  bit          no_gaps        = 1'b0;

  always #5 clk_i = ~clk_i;

  roman_numeral_encoder_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .value_i  (value_i),
    .valid_o  (valid_o),
    .symbol_o (symbol_o),
    .last_o   (last_o),
    .error_o  (error_o)
  );

  function automatic void queue_expected(input roman_char_t c);
    pending_chars = {pending_chars, c};
  endfunction

  // expected characters of one numeral, appended in output order
  function automatic void predict_numeral(input logic [ValueW-1:0] v);
    logic [SymW-1:0] unit_of [4];
    logic [SymW-1:0] five_of [4];
    logic [SymW-1:0] ten_of  [4];
    logic [SymW-1:0] chars   [16];
    int unsigned     n_chars;
    roman_char_t     c;
    int unsigned     digit;
    int unsigned     scale;
    int              place;
    unit_of = '{SymI, SymX, SymC, SymM};
    five_of = '{SymV, SymL, SymD, SymNone};
    ten_of  = '{SymX, SymC, SymM, SymNone};
    n_chars = 0;
    if (v == '0) return;
    if (v > MaxValid) begin
      c.symbol = SymNone;
      c.last   = 1'b1;
      c.error  = 1'b1;
      queue_expected(c);
      return;
    end
    scale = 1000;
    for (place = 3; place >= 0; place--) begin
      digit = (int'(v) / scale) % 10;
      scale = scale / 10;
      if (digit == 9) begin
        chars[n_chars] = unit_of[place];
        n_chars++;
        chars[n_chars] = ten_of[place];
        n_chars++;
      end else if (digit == 4) begin
        chars[n_chars] = unit_of[place];
        n_chars++;
        chars[n_chars] = five_of[place];
        n_chars++;
      end else begin
        if (digit >= 5) begin
          chars[n_chars] = five_of[place];
          n_chars++;
          digit = digit - 5;
        end
        repeat (digit) begin
          chars[n_chars] = unit_of[place];
          n_chars++;
        end
      end
    end
    for (int unsigned k = 0; k < n_chars; k++) begin
      c.symbol = chars[k];
      c.last   = (k == n_chars - 1);
      c.error  = 1'b0;
      queue_expected(c);
    end
  endfunction

  function automatic void flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: mismatch: %s", $time, what);
  endfunction

  // result check and item capture, both on pre-edge values
  always @(posedge clk_i) begin
    roman_char_t got;
    roman_char_t want;
    if (rst_ni) begin
      if (valid_o) begin
        got.symbol = symbol_o;
        got.last   = last_o;
        got.error  = error_o;
        if (pending_chars.size() == 0) begin
          flag_mismatch($sformatf("unexpected result symbol=%h last=%b error=%b",
                                  got.symbol, got.last, got.error));
        end else begin
          want = pending_chars.pop_front();
          if (got.symbol !== want.symbol || got.last !== want.last ||
              got.error !== want.error) begin
            flag_mismatch($sformatf(
              "exp symbol=%h last=%b error=%b, got symbol=%h last=%b error=%b",
              want.symbol, want.last, want.error, got.symbol, got.last, got.error));
          end
        end
      end
      if (start && !busy) predict_numeral(value_i);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // start stays high when the next item follows right away
  task automatic send_value(input logic [ValueW-1:0] v);
    int unsigned gap;
    start   <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    gap = pick_gap();
    if (gap != 0) begin
      start   <= 1'b0;
      value_i <= ValueW'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic test_zero_and_out_of_range();
    no_gaps = 1'b1;
    send_value(ValueW'(0));
    send_value(ValueW'(0));
    send_value(ValueW'(4000));
    send_value(ValueW'(4001));
    send_value(ValueW'(4095));
    send_value(ValueW'(1));
    send_value(ValueW'(3999));
    no_gaps = 1'b0;
  endtask

  task automatic test_digit_patterns();
    send_value(ValueW'(3888));
    send_value(ValueW'(1444));
    send_value(ValueW'(2999));
    send_value(ValueW'(1994));
    send_value(ValueW'(2765));
    send_value(ValueW'(1050));
    send_value(ValueW'(3000));
    send_value(ValueW'(500));
    send_value(ValueW'(90));
    send_value(ValueW'(6));
    send_value(ValueW'(7));
    send_value(ValueW'(40));
  endtask

  task automatic test_random_values(input int unsigned count);
    int unsigned r;
    for (int unsigned n = 0; n < count; n++) begin
      // occasional stretches of back-to-back items
      if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 78)      send_value(ValueW'($urandom_range(1, 3999)));
      else if (r < 88) send_value(ValueW'($urandom_range(4000, 4095)));
      else if (r < 93) send_value(ValueW'(0));
      else             send_value(ValueW'($urandom_range(1, 99)));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_and_out_of_range();
    test_digit_patterns();
    test_random_values(310);
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** roman_numeral_encoder_core: PASSED **");
    end else begin
      $display("** roman_numeral_encoder_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** roman_numeral_encoder_core: FAILED **");
    $finish;
  end

endmodule
